[design/sgm_pkg.sv]
// ----------------------------------------------------------------------------
// sgm_pkg: shared types and constants of the Sobel gradient magnitude block
// Widths, register indexes, queue entry layout and back end states used by
// the front end, the gradient queue, the back end and the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sgm_pkg;

  // Longest supported image row; sets the depth of both line stores.
  localparam int MAX_WIDTH = 1024;

  // Configuration register widths, as seen on the port.
  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  // Derived counter widths.
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int EFF_W_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W   = (EFF_W_W > IMG_W_W) ? EFF_W_W : IMG_W_W;
  localparam int ROW_W   = IMG_H_W + 1;

  // Datapath widths.
  localparam int PIX_W  = 8;
  localparam int GRAD_W = 12;
  localparam int SQ_W   = 2 * PIX_W + 1;
  localparam int ROOT_W = SQ_W + 1;

  // Gradient queue between front and back end.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_W-1:0]      cfg_data_t;
  typedef logic [IMG_W_W-1:0]    imgw_t;
  typedef logic [IMG_H_W-1:0]    hgt_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [EFF_W_W-1:0]    wid_t;
  typedef logic [CMP_W-1:0]      cmpw_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [ROW_W:0]        rowc_t;
  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [SQ_W-1:0]       sq_t;
  typedef logic [ROOT_W-1:0]     root_t;
  typedef logic [QPTR_W-1:0]     qptr_t;
  typedef logic [QCNT_W-1:0]     qcnt_t;
  typedef logic [QCNT_W:0]       qsum_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t REG_IMAGE_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_IMAGE_HEIGHT = cfg_idx_t'(1);

  // Register reset values.
  localparam imgw_t IMAGE_WIDTH_RST  = imgw_t'(640);
  localparam hgt_t  IMAGE_HEIGHT_RST = hgt_t'(480);

  // Largest pixel or saturated gradient value.
  localparam pix_t PIX_MAX = {PIX_W{1'b1}};

  // First trial bit of the square root: highest power of four in SQ_W bits.
  localparam sq_t ROOT_BIT_INIT = sq_t'(1) << (2 * ((SQ_W - 1) / 2));

  // One finished gradient pair waiting for its magnitude.
  typedef struct packed {
    pix_t grad_x;
    pix_t grad_y;
    logic eol;
    logic eof;
  } grad_item_t;

  // Window edge masks: which outer rows and columns lie inside the image.
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } win_mask_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROOT,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

[design/sgm_front.sv]
// ----------------------------------------------------------------------------
// sgm_front: pixel intake, line stores, window and Sobel responses
// Accepts pixels, keeps the position counters, reads and rewrites the two
// line stores, shifts the 3x3 window and pushes saturated gradients into the
// queue for every item that completes an output pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  sgm_pkg::cfg_idx_t   cfg_index,
  input  sgm_pkg::cfg_data_t  cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  sgm_pkg::pix_t       in_pixel,
  input  logic                in_fill,
  input  sgm_pkg::qcnt_t      q_count,
  output logic                push,
  output sgm_pkg::grad_item_t push_item
);

  // Configuration and position state.
  sgm_pkg::imgw_t width_r;
  sgm_pkg::hgt_t  height_r;
  sgm_pkg::col_t  col_r, col_nxt;
  sgm_pkg::row_t  row_r, row_nxt;

  // Line stores, registered read.
  sgm_pkg::pix_t upper_mem  [sgm_pkg::MAX_WIDTH];
  sgm_pkg::pix_t middle_mem [sgm_pkg::MAX_WIDTH];
  sgm_pkg::pix_t up_rd_r, mid_rd_r;

  // Stage one: item waiting for its line store data.
  logic              s1_v_r, s1_res_r, s1_eol_r, s1_eof_r;
  sgm_pkg::col_t     s1_addr_r;
  sgm_pkg::pix_t     s1_pix_r;
  sgm_pkg::win_mask_t s1_mask_r;
  logic              fwd_r;
  sgm_pkg::pix_t     fwd_up_r, fwd_mid_r;
  sgm_pkg::pix_t     up_eff, mid_eff;

  // Stage two: window complete, gradients computed.
  logic              s2_v_r, s2_eol_r, s2_eof_r;
  sgm_pkg::win_mask_t s2_mask_r;
  sgm_pkg::pix_t     win_r [9];

  // Classification of the accepted item.
  logic              accept;
  sgm_pkg::wid_t     w_eff;
  sgm_pkg::hgt_t     h_eff;
  logic              res_ok, eol, eof, col_wrap;
  sgm_pkg::col_t     cc;
  sgm_pkg::row_t     cr;
  sgm_pkg::win_mask_t mask;
  sgm_pkg::qsum_t    inflight;

  // Gradient datapath.
  sgm_pkg::grad_t    pe [9];
  sgm_pkg::grad_t    gx, gy;

  function automatic sgm_pkg::pix_t abs_sat(input sgm_pkg::grad_t v);
    sgm_pkg::grad_t a;
    a = v[sgm_pkg::GRAD_W-1] ? -v : v;
    abs_sat = (a > sgm_pkg::grad_t'(sgm_pkg::PIX_MAX)) ? sgm_pkg::PIX_MAX
                                                       : a[sgm_pkg::PIX_W-1:0];
  endfunction

  // Room check: every item in flight may still need a queue slot.
  assign inflight = sgm_pkg::qsum_t'(q_count) + sgm_pkg::qsum_t'(s1_v_r)
                  + sgm_pkg::qsum_t'(s2_v_r);
  assign in_ready = inflight < sgm_pkg::qsum_t'(sgm_pkg::QDEPTH);
  assign accept   = in_valid && in_ready;

  // Effective geometry, output position and edge masks.
  always_comb begin
    if (sgm_pkg::cmpw_t'(width_r) > sgm_pkg::cmpw_t'(sgm_pkg::MAX_WIDTH)) begin
      w_eff = sgm_pkg::wid_t'(sgm_pkg::MAX_WIDTH);
    end else if (width_r == '0) begin
      w_eff = sgm_pkg::wid_t'(1);
    end else begin
      w_eff = sgm_pkg::wid_t'(width_r);
    end
    h_eff = (height_r == '0) ? sgm_pkg::hgt_t'(1) : height_r;

    res_ok = (row_r >= sgm_pkg::row_t'(2)) ||
             ((row_r == sgm_pkg::row_t'(1)) && (col_r != '0));
    if (col_r != '0) begin
      cc = col_r - sgm_pkg::col_t'(1);
      cr = row_r - sgm_pkg::row_t'(1);
    end else begin
      cc = sgm_pkg::col_t'(w_eff - sgm_pkg::wid_t'(1));
      cr = row_r - sgm_pkg::row_t'(2);
    end

    eol           = (sgm_pkg::wid_t'(cc) + sgm_pkg::wid_t'(1)) == w_eff;
    mask.top_ok   = cr != '0;
    mask.bot_ok   = (sgm_pkg::rowc_t'(cr) + sgm_pkg::rowc_t'(1)) < sgm_pkg::rowc_t'(h_eff);
    mask.left_ok  = cc != '0;
    mask.right_ok = !eol;
    eof           = eol && !mask.bot_ok;

    col_wrap = (sgm_pkg::wid_t'(col_r) + sgm_pkg::wid_t'(1)) >= w_eff;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (res_ok && eof) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_r + sgm_pkg::row_t'(1);
      end else begin
        col_nxt = col_r + sgm_pkg::col_t'(1);
      end
    end
  end

  // Configuration registers and position counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sgm_pkg::IMAGE_WIDTH_RST;
      height_r <= sgm_pkg::IMAGE_HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      if (cfg_we && (cfg_index == sgm_pkg::REG_IMAGE_WIDTH)) begin
        width_r <= cfg_wdata[sgm_pkg::IMG_W_W-1:0];
      end
      if (cfg_we && (cfg_index == sgm_pkg::REG_IMAGE_HEIGHT)) begin
        height_r <= cfg_wdata[sgm_pkg::IMG_H_W-1:0];
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // The previous item writes its column in the same cycle as this read, so
  // with a one-pixel row the fresh values are taken from the forward path.
  assign up_eff  = fwd_r ? fwd_up_r  : up_rd_r;
  assign mid_eff = fwd_r ? fwd_mid_r : mid_rd_r;

  // Line stores: read at intake, rewritten in the cycle after.
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd_r  <= upper_mem[col_r];
      mid_rd_r <= middle_mem[col_r];
    end
    if (s1_v_r) begin
      upper_mem[s1_addr_r]  <= mid_eff;
      middle_mem[s1_addr_r] <= s1_pix_r;
    end
  end

  // Stage one registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      s1_v_r <= accept;
      fwd_r  <= accept && s1_v_r && (s1_addr_r == col_r);
    end
    if (accept) begin
      s1_addr_r <= col_r;
      s1_pix_r  <= in_fill ? '0 : in_pixel;
      s1_res_r  <= res_ok;
      s1_eol_r  <= eol;
      s1_eof_r  <= eof;
      s1_mask_r <= mask;
    end
    fwd_up_r  <= mid_eff;
    fwd_mid_r <= s1_pix_r;
  end

  // Window shift and stage two registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      s2_v_r <= s1_v_r && s1_res_r;
      if (s1_v_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r*3]   <= win_r[r*3+1];
          win_r[r*3+1] <= win_r[r*3+2];
        end
        win_r[2] <= up_eff;
        win_r[5] <= mid_eff;
        win_r[8] <= s1_pix_r;
      end
    end
    if (s1_v_r) begin
      s2_mask_r <= s1_mask_r;
      s2_eol_r  <= s1_eol_r;
      s2_eof_r  <= s1_eof_r;
    end
  end

  // Masked window and the two Sobel responses.
  always_comb begin
    logic row_ok, col_ok;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        row_ok = !(((r == 0) && !s2_mask_r.top_ok) || ((r == 2) && !s2_mask_r.bot_ok));
        col_ok = !(((c == 0) && !s2_mask_r.left_ok) || ((c == 2) && !s2_mask_r.right_ok));
        pe[r*3+c] = (row_ok && col_ok) ? sgm_pkg::grad_t'(win_r[r*3+c]) : '0;
      end
    end
    gx = (pe[2] - pe[0]) + ((pe[5] - pe[3]) <<< 1) + (pe[8] - pe[6]);
    gy = (pe[6] - pe[0]) + ((pe[7] - pe[1]) <<< 1) + (pe[8] - pe[2]);
  end

  assign push             = s2_v_r;
  assign push_item.grad_x = abs_sat(gx);
  assign push_item.grad_y = abs_sat(gy);
  assign push_item.eol    = s2_eol_r;
  assign push_item.eof    = s2_eof_r;

endmodule

`default_nettype wire

[design/sgm_queue.sv]
// ----------------------------------------------------------------------------
// sgm_queue: short gradient queue between front and back end
// A small circular buffer of gradient pairs; the front end only pushes when
// it has reserved a slot, the back end pops one pair per magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sgm_pkg::grad_item_t push_item,
  input  logic                pop,
  output logic                nempty,
  output sgm_pkg::grad_item_t head,
  output sgm_pkg::qcnt_t      count
);

  sgm_pkg::grad_item_t entry_r [sgm_pkg::QDEPTH];
  sgm_pkg::qptr_t      wr_ptr_r, rd_ptr_r;
  sgm_pkg::qcnt_t      count_r;

  assign nempty = count_r != '0;
  assign head   = entry_r[rd_ptr_r];
  assign count  = count_r;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + sgm_pkg::qptr_t'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + sgm_pkg::qptr_t'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + sgm_pkg::qcnt_t'(1);
      end else if (pop && !push) begin
        count_r <= count_r - sgm_pkg::qcnt_t'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[design/sgm_back.sv]
// ----------------------------------------------------------------------------
// sgm_back: gradient magnitude and result register
// Squares both gradients, takes the integer square root one result bit per
// cycle, saturates it and holds the finished result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_nempty,
  input  sgm_pkg::grad_item_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output sgm_pkg::pix_t       out_magnitude,
  output sgm_pkg::pix_t       out_grad_x,
  output sgm_pkg::pix_t       out_grad_y,
  output logic                out_end_of_line,
  output logic                out_end_of_frame
);

  sgm_pkg::back_state_t state_r, state_nxt;
  sgm_pkg::sq_t         n_r, n_nxt;
  sgm_pkg::sq_t         bit_r, bit_nxt;
  sgm_pkg::root_t       res_r, res_nxt;
  sgm_pkg::grad_item_t  item_r, item_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 load;
  sgm_pkg::pix_t        mag_r, mag_nxt;
  sgm_pkg::grad_item_t  out_item_r, out_item_nxt;
  logic [2*sgm_pkg::PIX_W-1:0] sq_x, sq_y;
  sgm_pkg::root_t       trial;

  assign sq_x  = (2*sgm_pkg::PIX_W)'(q_head.grad_x) * (2*sgm_pkg::PIX_W)'(q_head.grad_x);
  assign sq_y  = (2*sgm_pkg::PIX_W)'(q_head.grad_y) * (2*sgm_pkg::PIX_W)'(q_head.grad_y);
  assign trial = res_r + sgm_pkg::root_t'(bit_r);

  // Sequencer: pop and square, root iterations, hand over to output.
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    bit_nxt       = bit_r;
    res_nxt       = res_r;
    item_nxt      = item_r;
    q_pop         = 1'b0;
    load          = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    mag_nxt       = mag_r;
    out_item_nxt  = out_item_r;
    case (state_r)
      sgm_pkg::BK_IDLE: begin
        if (q_nempty) begin
          q_pop     = 1'b1;
          n_nxt     = sgm_pkg::sq_t'(sq_x) + sgm_pkg::sq_t'(sq_y);
          bit_nxt   = sgm_pkg::ROOT_BIT_INIT;
          res_nxt   = '0;
          item_nxt  = q_head;
          state_nxt = sgm_pkg::BK_ROOT;
        end
      end
      sgm_pkg::BK_ROOT: begin
        if (sgm_pkg::root_t'(n_r) >= trial) begin
          n_nxt   = sgm_pkg::sq_t'(sgm_pkg::root_t'(n_r) - trial);
          res_nxt = (res_r >> 1) + sgm_pkg::root_t'(bit_r);
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          state_nxt = sgm_pkg::BK_DONE;
        end
      end
      sgm_pkg::BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          mag_nxt       = (res_r > sgm_pkg::root_t'(sgm_pkg::PIX_MAX))
                          ? sgm_pkg::PIX_MAX : res_r[sgm_pkg::PIX_W-1:0];
          out_item_nxt  = item_r;
          state_nxt     = sgm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = sgm_pkg::BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgm_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    bit_r  <= bit_nxt;
    res_r  <= res_nxt;
    item_r <= item_nxt;
    if (load) begin
      mag_r      <= mag_nxt;
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_magnitude    = mag_r;
  assign out_grad_x       = out_item_r.grad_x;
  assign out_grad_y       = out_item_r.grad_y;
  assign out_end_of_line  = out_item_r.eol;
  assign out_end_of_frame = out_item_r.eof;

endmodule

`default_nettype wire

[design/sobel_gradient_magnitude.sv]
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude: streaming 3x3 Sobel gradient magnitude
// Gray pixels in raster order give |gx|, |gy| and floor(sqrt(gx^2+gy^2)),
// each saturated to 255, one image row plus one pixel behind the input.
//
//   Channel  Ports                                    Transfer when
//   input    in_valid/in_ready, in_pixel, in_fill     in_valid && in_ready
//   result   out_valid/out_ready, out_magnitude,      out_valid && out_ready
//            out_grad_x, out_grad_y, out_end_of_*
//   config   cfg_we, cfg_index, cfg_wdata             cfg_we
//
// Items that complete no output pixel pass the front end at one per cycle
// while in_ready is high. Each result passes the back end as a pop with squaring,
// nine square-root iterations of the shared root unit and a hand-over step.
// A four-entry queue lets the front end run ahead of the root unit; a full
// queue or a stalled output holds in_ready low.
// Reset is synchronous; the line stores hold no reset and need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_gradient_magnitude (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  sgm_pkg::cfg_idx_t  cfg_index,
  input  sgm_pkg::cfg_data_t cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  sgm_pkg::pix_t      in_pixel,
  input  logic               in_fill,
  output logic               out_valid,
  input  logic               out_ready,
  output sgm_pkg::pix_t      out_magnitude,
  output sgm_pkg::pix_t      out_grad_x,
  output sgm_pkg::pix_t      out_grad_y,
  output logic               out_end_of_line,
  output logic               out_end_of_frame
);

  logic                push, pop, q_nempty;
  sgm_pkg::grad_item_t push_item, q_head;
  sgm_pkg::qcnt_t      q_count;

  // Intake, line stores, window and Sobel responses.
  sgm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel),
    .in_fill   (in_fill),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  // Gradient queue.
  sgm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .nempty    (q_nempty),
    .head      (q_head),
    .count     (q_count)
  );

  // Magnitude and result register.
  sgm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_nempty         (q_nempty),
    .q_head           (q_head),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_magnitude    (out_magnitude),
    .out_grad_x       (out_grad_x),
    .out_grad_y       (out_grad_y),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

`default_nettype wire

[design/sgm_checker.sv]
// ----------------------------------------------------------------------------
// sgm_checker: port-level checks of the Sobel gradient magnitude block
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_we,
  input sgm_pkg::cfg_idx_t  cfg_index,
  input sgm_pkg::cfg_data_t cfg_wdata,
  input logic               in_valid,
  input logic               in_ready,
  input sgm_pkg::pix_t      in_pixel,
  input logic               in_fill,
  input logic               out_valid,
  input logic               out_ready,
  input sgm_pkg::pix_t      out_magnitude,
  input sgm_pkg::pix_t      out_grad_x,
  input sgm_pkg::pix_t      out_grad_y,
  input logic               out_end_of_line,
  input logic               out_end_of_frame
);

  // No result survives a reset.
  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result still offered after reset");

  // A stalled result keeps its whole payload.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_magnitude) &&
      $stable(out_grad_x) && $stable(out_grad_y) &&
      $stable(out_end_of_line) && $stable(out_end_of_frame))
    else $error("stalled result changed or vanished");

  // The last pixel of a frame is always the last of its row.
  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_end_of_line)
    else $error("frame end flagged away from a row end");

  // The magnitude lies between the larger gradient and the sum of both.
  a_magnitude_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_magnitude >= out_grad_x) && (out_magnitude >= out_grad_y) &&
      ((sgm_pkg::PIX_W + 1)'(out_magnitude) <=
       (sgm_pkg::PIX_W + 1)'(out_grad_x) + (sgm_pkg::PIX_W + 1)'(out_grad_y)))
    else $error("magnitude outside the bounds set by its gradients");

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (.*);

`default_nettype wire
